FILE: hdl/assert_macros.svh
// Assertion macros shared by the compositor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ACP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ACP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: hdl/acp_pkg.sv
// Shared types, codes and constants of the alpha compositor.
package acp_pkg;

	localparam int MAX_COLOURS_DEF = 4;
	localparam int VALUE_WIDTH_DEF = 16;
	localparam int COLOUR_PORTS    = 4;
	localparam int ADDR_W          = 5;
	localparam int FRAC_BITS       = 16;
	localparam int FW              = FRAC_BITS + 1;
	localparam logic [FW-1:0] FRAC_ONE = FW'(1) << FRAC_BITS;

	typedef enum logic [3:0] {
		OP_CLEAR     = 4'd0,
		OP_COPY      = 4'd1,
		OP_SOVER     = 4'd2,
		OP_SIN       = 4'd3,
		OP_SOUT      = 4'd4,
		OP_SATOP     = 4'd5,
		OP_DOVER     = 4'd6,
		OP_DIN       = 4'd7,
		OP_DOUT      = 4'd8,
		OP_DATOP     = 4'd9,
		OP_XOR       = 4'd10,
		OP_PLUSD     = 4'd11,
		OP_PLUSL     = 4'd12,
		OP_HIGHLIGHT = 4'd13,
		OP_DISSOLVE  = 4'd14
	} op_t;

	typedef enum logic [2:0] {
		REG_OP         = 3'd0,
		REG_COLOURS    = 3'd1,
		REG_SRC_BITS   = 3'd2,
		REG_DST_BITS   = 3'd3,
		REG_DISSOLVE   = 3'd4,
		REG_CONST_A    = 3'd5,
		REG_SRC_A_PRES = 3'd6,
		REG_DST_A_PRES = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [3:0]    op;
		logic [2:0]    colour_count;
		logic [4:0]    source_bits;
		logic [4:0]    dest_bits;
		logic [FW-1:0] dissolve_fraction;
		logic [15:0]   constant_source_alpha;
		logic          source_alpha_present;
		logic          dest_alpha_present;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		op:                    4'd1,
		colour_count:          3'd3,
		source_bits:           5'd8,
		dest_bits:             5'd8,
		dissolve_fraction:     FRAC_ONE,
		constant_source_alpha: 16'd255,
		source_alpha_present:  1'b0,
		dest_alpha_present:    1'b0
	};

endpackage

FILE: hdl/acp_cfg.sv
// APB register file holding the compositor configuration.
`include "assert_macros.svh"

module acp_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [acp_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output acp_pkg::cfg_t             cfg
);

	acp_pkg::cfg_t     cfg_q;
	acp_pkg::reg_idx_t idx;
	logic              wr_en;

	assign pready = 1'b1;
	assign idx    = acp_pkg::reg_idx_t'(paddr[acp_pkg::ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= acp_pkg::CFG_RESET;
		end else if (wr_en) begin
			case (idx)
				acp_pkg::REG_OP:         cfg_q.op <= pwdata[3:0];
				acp_pkg::REG_COLOURS:    cfg_q.colour_count <= pwdata[2:0];
				acp_pkg::REG_SRC_BITS:   cfg_q.source_bits <= pwdata[4:0];
				acp_pkg::REG_DST_BITS:   cfg_q.dest_bits <= pwdata[4:0];
				acp_pkg::REG_DISSOLVE:   cfg_q.dissolve_fraction <= pwdata[acp_pkg::FW-1:0];
				acp_pkg::REG_CONST_A:    cfg_q.constant_source_alpha <= pwdata[15:0];
				acp_pkg::REG_SRC_A_PRES: cfg_q.source_alpha_present <= pwdata[0];
				acp_pkg::REG_DST_A_PRES: cfg_q.dest_alpha_present <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			acp_pkg::REG_OP:         prdata = 32'(cfg_q.op);
			acp_pkg::REG_COLOURS:    prdata = 32'(cfg_q.colour_count);
			acp_pkg::REG_SRC_BITS:   prdata = 32'(cfg_q.source_bits);
			acp_pkg::REG_DST_BITS:   prdata = 32'(cfg_q.dest_bits);
			acp_pkg::REG_DISSOLVE:   prdata = 32'(cfg_q.dissolve_fraction);
			acp_pkg::REG_CONST_A:    prdata = 32'(cfg_q.constant_source_alpha);
			acp_pkg::REG_SRC_A_PRES: prdata = 32'(cfg_q.source_alpha_present);
			acp_pkg::REG_DST_A_PRES: prdata = 32'(cfg_q.dest_alpha_present);
			default:                 prdata = '0;
		endcase
	end

	`ACP_ASSERT_NEXT(a_op_write, wr_en && idx == acp_pkg::REG_OP, cfg_q.op == $past(pwdata[3:0]))

endmodule

FILE: hdl/acp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
module acp_div #(
	parameter int VW = 16,
	parameter int QW = 16,
	parameter int TW = 16
) (
	input  logic             clk,
	input  logic [VW+QW-1:0] x,
	input  logic [VW-1:0]    m,
	input  logic [TW-1:0]    tag_in,
	output logic [QW-1:0]    q,
	output logic [VW-1:0]    r,
	output logic [TW-1:0]    tag_out
);

	localparam int NW = VW + QW;

	logic [VW-1:0] rem_s [QW];
	logic [QW-1:0] xlo_s [QW];
	logic [QW-1:0] quo_s [QW];
	logic [TW-1:0] tag_s [QW];

	// quotient fits QW bits, so the top of x is already below m
	for (genvar i = 0; i < QW; i++) begin : g_step
		logic [VW-1:0] rem_in;
		logic [QW-1:0] xlo_in;
		logic [QW-1:0] quo_in;
		logic [TW-1:0] tag_inp;
		logic [VW:0]   trial;
		logic          fits;

		if (i == 0) begin : g_first
			assign rem_in  = x[NW-1:QW];
			assign xlo_in  = x[QW-1:0];
			assign quo_in  = '0;
			assign tag_inp = tag_in;
		end else begin : g_next
			assign rem_in  = rem_s[i-1];
			assign xlo_in  = xlo_s[i-1];
			assign quo_in  = quo_s[i-1];
			assign tag_inp = tag_s[i-1];
		end

		always_comb begin
			trial = {rem_in, xlo_in[QW-1-i]};
			fits  = trial >= {1'b0, m};
		end

		always_ff @(posedge clk) begin
			rem_s[i] <= fits ? VW'(trial - {1'b0, m}) : trial[VW-1:0];
			xlo_s[i] <= xlo_in;
			quo_s[i] <= quo_in | (QW'(fits) << (QW - 1 - i));
			tag_s[i] <= tag_inp;
		end
	end

	assign q       = quo_s[QW-1];
	assign r       = rem_s[QW-1];
	assign tag_out = tag_s[QW-1];

endmodule

FILE: hdl/acp_lane.sv
// One value lane: products, divisions by the source maximum, operator select.
module acp_lane #(
	parameter int VW        = 16,
	parameter int QW        = 16,
	parameter bit IS_COLOUR = 1'b1
) (
	input  logic                   clk,
	input  logic [3:0]             op,
	input  logic [VW-1:0]          smax,
	input  logic [VW-1:0]          dmax,
	input  logic [acp_pkg::FW-1:0] frac,
	input  logic [VW-1:0]          s,
	input  logic [VW-1:0]          d,
	input  logic [VW-1:0]          as,
	input  logic [VW-1:0]          ad,
	output logic [VW-1:0]          res
);

	localparam int FW = acp_pkg::FW;
	localparam int NW = VW + QW;
	localparam int TW = VW + 2 * NW;

	logic [VW-1:0] w1, w2;
	logic [NW-1:0] x1_s2, x2_s2;
	logic [VW-1:0] s_s2, d_s2;

	logic [QW-1:0] q1, q2, q3;
	logic [VW-1:0] r1, s_a, d_a;
	logic [VW-1:0] q1v, q2v;

	logic [VW:0]   t_sq2, t_q12, t_q1d, t_sd;
	logic [VW:0]   nd_raw;
	logic [VW-1:0] nd_c;
	logic [NW-1:0] x3_c, p1_c, p2_c;

	logic [NW-1:0] x3_s3;
	logic [TW-1:0] tag_s3, tag_b;

	logic [VW-1:0] nd_b, dis;
	logic [NW-1:0] p1_b, p2_b, sum_b;
	logic [VW-1:0] res_s4;

	always_comb begin
		if (op inside {acp_pkg::OP_SIN, acp_pkg::OP_SATOP}) begin
			w1 = ad;
		end else if (op == acp_pkg::OP_DISSOLVE) begin
			w1 = dmax;
		end else begin
			w1 = dmax - ad;
		end
		if (op inside {acp_pkg::OP_DIN, acp_pkg::OP_DATOP}) begin
			w2 = as;
		end else begin
			w2 = smax - as;
		end
	end

	always_ff @(posedge clk) begin
		x1_s2 <= NW'({{VW{1'b0}}, s} * {{VW{1'b0}}, w1});
		x2_s2 <= NW'({{VW{1'b0}}, d} * {{VW{1'b0}}, w2});
		s_s2  <= s;
		d_s2  <= d;
	end

	acp_div #(.VW(VW), .QW(QW), .TW(VW)) u_div_a1 (
		.clk     (clk),
		.x       (x1_s2),
		.m       (smax),
		.tag_in  (s_s2),
		.q       (q1),
		.r       (r1),
		.tag_out (s_a)
	);

	acp_div #(.VW(VW), .QW(QW), .TW(VW)) u_div_a2 (
		.clk     (clk),
		.x       (x2_s2),
		.m       (smax),
		.tag_in  (d_s2),
		.q       (q2),
		.r       (),
		.tag_out (d_a)
	);

	function automatic logic [VW-1:0] sat(input logic [VW:0] v, input logic [VW-1:0] lim);
		return (v > {1'b0, lim}) ? lim : v[VW-1:0];
	endfunction

	always_comb begin
		q1v   = q1[VW-1:0];
		q2v   = q2[VW-1:0];
		t_sq2 = {1'b0, s_a} + {1'b0, q2v};
		t_q12 = {1'b0, q1v} + {1'b0, q2v};
		t_q1d = {1'b0, q1v} + {1'b0, d_a};
		t_sd  = {1'b0, s_a} + {1'b0, d_a};
		case (op)
			acp_pkg::OP_CLEAR:  nd_raw = '0;
			acp_pkg::OP_COPY:   nd_raw = {1'b0, s_a};
			acp_pkg::OP_SOVER:  nd_raw = {1'b0, sat(t_sq2, dmax)};
			acp_pkg::OP_SIN:    nd_raw = {1'b0, q1v};
			acp_pkg::OP_SOUT:   nd_raw = {1'b0, q1v};
			acp_pkg::OP_SATOP:  nd_raw = {1'b0, sat(t_q12, dmax)};
			acp_pkg::OP_DOVER:  nd_raw = {1'b0, sat(t_q1d, dmax)};
			acp_pkg::OP_DIN:    nd_raw = {1'b0, q2v};
			acp_pkg::OP_DOUT:   nd_raw = {1'b0, q2v};
			acp_pkg::OP_DATOP:  nd_raw = {1'b0, sat(t_q12, dmax)};
			acp_pkg::OP_XOR:    nd_raw = {1'b0, sat(t_q12, dmax)};
			acp_pkg::OP_PLUSD:  nd_raw = (t_sd < {1'b0, dmax}) ? '0 : t_sd - {1'b0, dmax};
			acp_pkg::OP_PLUSL:  nd_raw = {1'b0, sat(t_sd, dmax)};
			acp_pkg::OP_HIGHLIGHT: begin
				if (IS_COLOUR && (((s_a ^ dmax) & ~VW'(1)) == '0)) begin
					nd_raw = {1'b0, s_a ^ VW'(1)};
				end else begin
					nd_raw = {1'b0, s_a};
				end
			end
			default:            nd_raw = '0;
		endcase
		nd_c = nd_raw[VW-1:0] & dmax;
		x3_c = NW'({{VW{1'b0}}, frac} * {{FW{1'b0}}, r1});
		p1_c = NW'({{VW{1'b0}}, frac} * {{FW{1'b0}}, q1v});
		p2_c = NW'({{FW{1'b0}}, d_a} * {{VW{1'b0}}, acp_pkg::FRAC_ONE - frac});
	end

	always_ff @(posedge clk) begin
		x3_s3  <= x3_c;
		tag_s3 <= {nd_c, p1_c, p2_c};
	end

	acp_div #(.VW(VW), .QW(QW), .TW(TW)) u_div_b (
		.clk     (clk),
		.x       (x3_s3),
		.m       (smax),
		.tag_in  (tag_s3),
		.q       (q3),
		.r       (),
		.tag_out (tag_b)
	);

	always_comb begin
		{nd_b, p1_b, p2_b} = tag_b;
		sum_b = p1_b + p2_b + NW'(q3);
		dis   = sum_b[NW-1:QW] & dmax;
	end

	always_ff @(posedge clk) begin
		res_s4 <= (op == acp_pkg::OP_DISSOLVE) ? dis : nd_b;
	end

	assign res = res_s4;

endmodule

FILE: hdl/alpha_composite_pixel.sv
// Top level of the pipelined Porter-Duff pixel compositor.
// Usage:
//  - Configure through the APB port (8 registers at byte offsets 4*i) while idle.
//  - Drive one pixel with start high; busy is always low, so a pixel can be
//    transferred on every cycle.
//  - Each pixel produces one result; done is high for exactly one cycle with
//    comp_alpha, result_c0..result_c3 and range_error valid in that cycle.
//  - The pixel path runs through the input register, the two chained pipelined
//    divisions by the source maximum and the output register; these set the
//    depth from start to done.
//  - Throughput: one pixel per clock, sustained.
//  - Colour lanes and the alpha lane run in parallel; colours beyond the
//    configured count, and the alpha and colours of an erroring pixel, come out as zero.
//  - Reset clears the configuration to its defaults and drops all pixels in
//    flight; no done strobe follows reset until a new pixel is transferred.
//  - The receiver cannot stall: a result is present for one cycle only.
`include "assert_macros.svh"

module alpha_composite_pixel #(
	parameter int MAX_COLOURS = acp_pkg::MAX_COLOURS_DEF,
	parameter int VALUE_WIDTH = acp_pkg::VALUE_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [acp_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       start,
	output logic                       busy,
	input  logic [VALUE_WIDTH-1:0]     source_alpha_value,
	input  logic [VALUE_WIDTH-1:0]     dest_alpha_value,
	input  logic [VALUE_WIDTH-1:0]     source_c0,
	input  logic [VALUE_WIDTH-1:0]     source_c1,
	input  logic [VALUE_WIDTH-1:0]     source_c2,
	input  logic [VALUE_WIDTH-1:0]     source_c3,
	input  logic [VALUE_WIDTH-1:0]     dest_c0,
	input  logic [VALUE_WIDTH-1:0]     dest_c1,
	input  logic [VALUE_WIDTH-1:0]     dest_c2,
	input  logic [VALUE_WIDTH-1:0]     dest_c3,
	output logic                       done,
	output logic [VALUE_WIDTH-1:0]     comp_alpha,
	output logic [VALUE_WIDTH-1:0]     result_c0,
	output logic [VALUE_WIDTH-1:0]     result_c1,
	output logic [VALUE_WIDTH-1:0]     result_c2,
	output logic [VALUE_WIDTH-1:0]     result_c3,
	output logic                       range_error
);

	localparam int VW  = VALUE_WIDTH;
	localparam int QW  = acp_pkg::FRAC_BITS;
	localparam int NP  = acp_pkg::COLOUR_PORTS;
	localparam int LAT = 2 * QW + 3;
	localparam logic [VW-1:0] ONES = {VW{1'b1}};

	acp_pkg::cfg_t cfg;

	logic [4:0]             sb, db;
	logic [2:0]             n;
	logic [VW-1:0]          smax, dmax;
	logic [acp_pkg::FW-1:0] frac;
	logic [VW-1:0]          as_c, ad_c;
	logic                   need_a, need_s, err_c;
	logic                   xfer;

	logic [VW-1:0] src_in [NP];
	logic [VW-1:0] dst_in [NP];

	logic          valid_s1, err_s1;
	logic [VW-1:0] as_s1, ad_s1;
	logic [VW-1:0] s_s1 [NP];
	logic [VW-1:0] d_s1 [NP];

	logic          vld_s [LAT];
	logic          err_s [LAT];

	logic [VW-1:0] alpha_res;
	logic [VW-1:0] col_res [NP];

	logic          done_q, err_q;
	logic [VW-1:0] alpha_q;
	logic [VW-1:0] col_q [NP];
	logic [NP-1:0] col_en_q;

	acp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign busy = 1'b0;
	assign xfer = start && !busy;

	assign src_in[0] = source_c0;
	assign src_in[1] = source_c1;
	assign src_in[2] = source_c2;
	assign src_in[3] = source_c3;
	assign dst_in[0] = dest_c0;
	assign dst_in[1] = dest_c1;
	assign dst_in[2] = dest_c2;
	assign dst_in[3] = dest_c3;

	always_comb begin
		if (cfg.source_bits == '0) begin
			sb = 5'd1;
		end else if (cfg.source_bits > 5'(VW)) begin
			sb = 5'(VW);
		end else begin
			sb = cfg.source_bits;
		end
		if (cfg.dest_bits == '0) begin
			db = 5'd1;
		end else if (cfg.dest_bits > 5'(VW)) begin
			db = 5'(VW);
		end else begin
			db = cfg.dest_bits;
		end
		if (cfg.colour_count == '0) begin
			n = 3'd1;
		end else if (cfg.colour_count > 3'(MAX_COLOURS)) begin
			n = 3'(MAX_COLOURS);
		end else begin
			n = cfg.colour_count;
		end
		smax = ONES >> (5'(VW) - sb);
		dmax = ONES >> (5'(VW) - db);
		frac = (cfg.dissolve_fraction > acp_pkg::FRAC_ONE) ? acp_pkg::FRAC_ONE
			: cfg.dissolve_fraction;

		if (cfg.source_alpha_present) begin
			as_c = source_alpha_value & smax;
		end else if (cfg.constant_source_alpha > 16'(smax)) begin
			as_c = smax;
		end else begin
			as_c = cfg.constant_source_alpha[VW-1:0];
		end
		ad_c = cfg.dest_alpha_present ? (dest_alpha_value & dmax) : dmax;

		need_a = cfg.op inside {acp_pkg::OP_CLEAR, acp_pkg::OP_SOUT, acp_pkg::OP_DOUT,
			acp_pkg::OP_XOR};
		need_s = need_a || (cfg.op inside {acp_pkg::OP_COPY, acp_pkg::OP_SIN,
			acp_pkg::OP_DIN, acp_pkg::OP_DATOP, acp_pkg::OP_PLUSD,
			acp_pkg::OP_HIGHLIGHT, acp_pkg::OP_DISSOLVE});
		if (cfg.op > acp_pkg::OP_DISSOLVE) begin
			err_c = 1'b1;
		end else if (!cfg.dest_alpha_present) begin
			err_c = (cfg.source_alpha_present || as_c != smax) ? need_s : need_a;
		end else begin
			err_c = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= xfer;
		end
	end

	always_ff @(posedge clk) begin
		err_s1 <= err_c;
		as_s1  <= as_c;
		ad_s1  <= ad_c;
		for (int j = 0; j < NP; j++) begin
			s_s1[j] <= src_in[j] & smax;
			d_s1[j] <= dst_in[j] & dmax;
		end
	end

	acp_lane #(.VW(VW), .QW(QW), .IS_COLOUR(1'b0)) u_lane_alpha (
		.clk  (clk),
		.op   (cfg.op),
		.smax (smax),
		.dmax (dmax),
		.frac (frac),
		.s    (as_s1),
		.d    (ad_s1),
		.as   (as_s1),
		.ad   (ad_s1),
		.res  (alpha_res)
	);

	for (genvar j = 0; j < NP; j++) begin : g_col
		if (j < MAX_COLOURS) begin : g_lane
			acp_lane #(.VW(VW), .QW(QW), .IS_COLOUR(1'b1)) u_lane (
				.clk  (clk),
				.op   (cfg.op),
				.smax (smax),
				.dmax (dmax),
				.frac (frac),
				.s    (s_s1[j]),
				.d    (d_s1[j]),
				.as   (as_s1),
				.ad   (ad_s1),
				.res  (col_res[j])
			);
		end else begin : g_none
			assign col_res[j] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			vld_s[0] <= valid_s1;
			for (int k = 1; k < LAT; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		err_s[0] <= err_s1;
		for (int k = 1; k < LAT; k++) begin
			err_s[k] <= err_s[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		err_q   <= err_s[LAT-1];
		alpha_q <= err_s[LAT-1] ? '0 : alpha_res;
		for (int j = 0; j < NP; j++) begin
			col_en_q[j] <= (3'(j) < n) && (j < MAX_COLOURS) && !err_s[LAT-1];
			col_q[j]    <= ((3'(j) < n) && (j < MAX_COLOURS) && !err_s[LAT-1])
				? col_res[j] : '0;
		end
	end

	assign done        = done_q;
	assign range_error = err_q;
	assign comp_alpha  = alpha_q;
	assign result_c0   = col_q[0];
	assign result_c1   = col_q[1];
	assign result_c2   = col_q[2];
	assign result_c3   = col_q[3];

	`ACP_ASSERT_NOW(a_err_zero, done && range_error, comp_alpha == '0 && result_c0 == '0 && result_c1 == '0 && result_c2 == '0 && result_c3 == '0)
	`ACP_ASSERT_NOW(a_unused_zero, done && !col_en_q[3], result_c3 == '0)

endmodule
